/* rtl/core/cdss_pkg.sv */
// ----------------------------------------------------------------------------
// cdss_pkg
// Shared types and constants of the CD sector sync tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cdss_pkg;

    localparam int unsigned LBA_W  = 21;
    localparam int unsigned WORD_W = 32;

    typedef logic signed [LBA_W-1:0] t_lba;
    typedef logic [WORD_W-1:0]       t_word;
    typedef logic [1:0]              t_sync;

    // sync words matched so far; SYNC_HDR means the next item is the header
    localparam t_sync SYNC_NONE = 2'd0;
    localparam t_sync SYNC_HDR  = 2'd3;

    localparam t_word SYNC_WORD_0 = 32'hFFFF_FF00;
    localparam t_word SYNC_WORD_1 = 32'hFFFF_FFFF;
    localparam t_word SYNC_WORD_2 = 32'h00FF_FFFF;

    localparam t_word SYNC_LEN           = 32'd3;
    localparam t_word SAMPLES_PER_SECTOR = 32'd588;

    localparam logic [7:0] SCRAMBLE_M = 8'h01;
    localparam logic [7:0] SCRAMBLE_S = 8'h80;
    localparam logic [7:0] SCRAMBLE_F = 8'h00;

    localparam logic [7:0]       MIN_WRAP    = 8'd90;
    localparam logic [LBA_W-1:0] LBA_PREGAP  = 21'd150;
    localparam logic [LBA_W-1:0] LBA_WRAP    = 21'd450000;

    function automatic t_word sync_word(input t_sync idx);
        t_word w;
        case (idx)
            2'd0:    w = SYNC_WORD_0;
            2'd1:    w = SYNC_WORD_1;
            2'd2:    w = SYNC_WORD_2;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cdss_if.sv */
// ----------------------------------------------------------------------------
// cdss_if
// Valid/ready channels: sample items in, sector records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdss_in_if;
    logic                 valid;
    logic                 ready;
    cdss_pkg::t_word      sample_word;
    logic                 sample_bad;
    cdss_pkg::t_word      sample_position;

    modport source (output valid, output sample_word, output sample_bad,
                    output sample_position, input ready);
    modport sink   (input valid, input sample_word, input sample_bad,
                    input sample_position, output ready);
endinterface

interface cdss_out_if;
    logic                 valid;
    logic                 ready;
    cdss_pkg::t_lba       sector_lba;
    cdss_pkg::t_word      sector_offset;
    logic                 starts_group;
    cdss_pkg::t_lba       group_first_lba;
    cdss_pkg::t_word      group_offset;
    cdss_pkg::t_word      group_count;

    modport source (output valid, output sector_lba, output sector_offset,
                    output starts_group, output group_first_lba,
                    output group_offset, output group_count, input ready);
    modport sink   (input valid, input sector_lba, input sector_offset,
                    input starts_group, input group_first_lba,
                    input group_offset, input group_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/cdss_lba_decode.sv */
// ----------------------------------------------------------------------------
// cdss_lba_decode
// Sector header word to LBA: optional descramble, BCD decode of M/S/F.
// ----------------------------------------------------------------------------
`default_nettype none

module cdss_lba_decode (
    input  cdss_pkg::t_word i_word,
    input  logic            i_raw,
    output cdss_pkg::t_lba  o_lba
);

    function automatic logic [7:0] bcd(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
    endfunction

    logic [7:0]                   mb, sb, fb;
    logic [7:0]                   m, s, f;
    logic [13:0]                  ms;
    logic [cdss_pkg::LBA_W-1:0]   msf;
    logic [cdss_pkg::LBA_W-1:0]   lba_u;

    always_comb begin
        mb = i_word[7:0];
        sb = i_word[15:8];
        fb = i_word[23:16];
        if (!i_raw) begin
            mb = mb ^ cdss_pkg::SCRAMBLE_M;
            sb = sb ^ cdss_pkg::SCRAMBLE_S;
            fb = fb ^ cdss_pkg::SCRAMBLE_F;
        end
        m     = bcd(mb);
        s     = bcd(sb);
        f     = bcd(fb);
        ms    = 14'({6'd0, m} * 14'd60) + {6'd0, s};
        msf   = cdss_pkg::LBA_W'({7'd0, ms} * 21'd75);
        lba_u = msf + {13'd0, f} - cdss_pkg::LBA_PREGAP;
        if (m >= cdss_pkg::MIN_WRAP) begin
            lba_u = lba_u - cdss_pkg::LBA_WRAP;
        end
    end

    assign o_lba = cdss_pkg::t_lba'(lba_u);

endmodule

`default_nettype wire

/* rtl/core/cd_sector_sync_tracker.sv */
// ----------------------------------------------------------------------------
// cd_sector_sync_tracker
// Finds CD data sync in an audio sample stream, decodes each sector header
// to an LBA and tracks runs of sectors that sit 588 samples per LBA apart.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one sample item per handshake (word, bad flag, position).
//   o_out carries one sector record per header found after the three sync
//   words; items that are not headers give no record.
//   i_cfg_we/i_cfg_wdata write raw_header (1 = no header descramble); write
//   it only while the block is idle.
// Timing:
//   Three registers deep: input stage, header stage, output stage. A record
//   moves from the input stage through the header stage to the output
//   stage. One item per cycle sustained while o_out is ready, set by the
//   single group compare in the header stage.
// Stall:
//   A stalled output holds its record; the input and header stages keep
//   taking items until each holds one, then i_in.ready drops.
// Reset:
//   Synchronous, active low; clears sync progress, the group and all
//   stage valids, and sets raw_header to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_sector_sync_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    cdss_in_if.sink           i_in,
    cdss_out_if.source        o_out
);

    logic                    r_raw;

    logic                    en_a, en_b, en_o;

    logic                    r_a_vld;
    cdss_pkg::t_word         r_a_word;
    logic                    r_a_bad;
    cdss_pkg::t_word         r_a_pos;

    cdss_pkg::t_sync         r_sync, n_sync;
    logic                    a_fire, a_hdr;
    cdss_pkg::t_lba          a_lba;

    logic                    r_b_vld;
    cdss_pkg::t_lba          r_b_lba;
    cdss_pkg::t_word         r_b_off;

    logic                    b_fire, b_join;
    cdss_pkg::t_word         b_lba_ext, b_key;

    logic                    r_have;
    cdss_pkg::t_lba          r_first;
    cdss_pkg::t_word         r_start, r_key, r_cnt;
    cdss_pkg::t_word         n_cnt;

    logic                    r_o_vld;
    cdss_pkg::t_lba          r_o_lba, r_o_first;
    cdss_pkg::t_word         r_o_off, r_o_goff, r_o_cnt;
    logic                    r_o_starts;

    assign en_o = !r_o_vld || o_out.ready;
    assign en_b = !r_b_vld || en_o;
    assign en_a = !r_a_vld || en_b;

    assign i_in.ready = en_a;

    // stage A: sync search and header decode
    assign a_fire = r_a_vld && en_b;
    assign a_hdr  = !r_a_bad && (r_sync == cdss_pkg::SYNC_HDR);

    always_comb begin
        n_sync = r_sync;
        if (a_fire) begin
            if (r_a_bad || r_sync == cdss_pkg::SYNC_HDR) begin
                n_sync = cdss_pkg::SYNC_NONE;
            end else if (r_a_word == cdss_pkg::sync_word(r_sync)) begin
                n_sync = r_sync + 2'd1;
            end else begin
                n_sync = cdss_pkg::SYNC_NONE;
            end
        end
    end

    cdss_lba_decode u_lba_decode (
        .i_word (r_a_word),
        .i_raw  (r_raw),
        .o_lba  (a_lba)
    );

    // stage B: group match, lba*588 - offset against the group's key
    assign b_fire    = r_b_vld && en_o;
    assign b_lba_ext = cdss_pkg::t_word'(r_b_lba);
    assign b_key     = (b_lba_ext << 9) + (b_lba_ext << 6) + (b_lba_ext << 3)
                     + (b_lba_ext << 2) - r_b_off;
    assign b_join    = r_have && (b_key == r_key);
    assign n_cnt     = (r_cnt == '1) ? r_cnt : r_cnt + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= 1'b0;
            r_sync  <= cdss_pkg::SYNC_NONE;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_raw <= i_cfg_wdata;
            end
            r_sync <= n_sync;
            if (en_a) begin
                r_a_vld <= i_in.valid;
            end
            if (en_b) begin
                r_b_vld <= a_fire && a_hdr;
            end
            if (en_o) begin
                r_o_vld <= r_b_vld;
            end
            if (b_fire) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_in.valid) begin
            r_a_word <= i_in.sample_word;
            r_a_bad  <= i_in.sample_bad;
            r_a_pos  <= i_in.sample_position;
        end
        if (a_fire && a_hdr) begin
            r_b_lba <= a_lba;
            r_b_off <= r_a_pos - cdss_pkg::SYNC_LEN;
        end
        if (b_fire) begin
            r_o_lba    <= r_b_lba;
            r_o_off    <= r_b_off;
            r_o_starts <= !b_join;
            if (b_join) begin
                r_cnt     <= n_cnt;
                r_o_cnt   <= n_cnt;
                r_o_first <= r_first;
                r_o_goff  <= r_start;
            end else begin
                r_first   <= r_b_lba;
                r_start   <= r_b_off;
                r_key     <= b_key;
                r_cnt     <= 32'd1;
                r_o_cnt   <= 32'd1;
                r_o_first <= r_b_lba;
                r_o_goff  <= r_b_off;
            end
        end
    end

    assign o_out.valid           = r_o_vld;
    assign o_out.sector_lba      = r_o_lba;
    assign o_out.sector_offset   = r_o_off;
    assign o_out.starts_group    = r_o_starts;
    assign o_out.group_first_lba = r_o_first;
    assign o_out.group_offset    = r_o_goff;
    assign o_out.group_count     = r_o_cnt;

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_sync == cdss_pkg::SYNC_NONE && !r_a_vld && !r_b_vld && !r_o_vld))
        else $error("reset left state behind");

    a_new_group_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.starts_group) |-> (o_out.group_count == 32'd1))
        else $error("new group without count of one");

    a_join_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.starts_group) |-> (o_out.group_count > 32'd1))
        else $error("joined sector with count below two");

    a_new_group_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.starts_group) |->
        (o_out.group_first_lba == o_out.sector_lba &&
         o_out.group_offset == o_out.sector_offset))
        else $error("new group head differs from its sector");

    a_hdr_after_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && a_hdr) |=> (r_sync == cdss_pkg::SYNC_NONE))
        else $error("sync progress not cleared after header");
`endif

endmodule

`default_nettype wire
